@@ src/svmc_pkg.sv @@
// Shared types, constants and sector tables for the space vector compare block.
// Depends on nothing; every other file of the block imports it.
package svmc_pkg;

  localparam logic [14:0] DRIVE_MAX  = 15'd28378;
  localparam logic [16:0] PI3        = 17'd68629;
  localparam logic [16:0] ONE_DEG    = 17'd1144;
  localparam logic [16:0] DEG_HI     = 17'd67485;
  localparam logic [16:0] SIN_C1     = 17'd83443;
  localparam logic [14:0] SIN_C2     = 15'd26561;
  localparam logic [15:0] HALF_RESET = 16'd4000;

  typedef enum logic [1:0] {
    REG_HALF  = 2'd0,
    REG_DEAD  = 2'd1,
    REG_NOISE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [16:0] xa;
    logic [16:0] xb;
  } svmc_side_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [30:0] tnh;
    logic [31:0] ta;
    logic [31:0] tb;
  } svmc_tim_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [1:0]  phase_b;
    logic [1:0]  phase_a;
    logic        rising;
    logic [15:0] adc;
    logic [15:0] p3;
    logic [15:0] p2;
    logic [15:0] p1;
  } svmc_res_t;

  // Sources of t1..t3, packed {t3, t2, t1}: 0 tn_half, 1 ton1, 2 ton2, 3 ton3.
  function automatic logic [5:0] sec_src(input logic [2:0] s);
    logic [5:0] r;
    unique case (s)
      3'd0:    r = {2'd3, 2'd1, 2'd0};
      3'd1:    r = {2'd3, 2'd0, 2'd2};
      3'd2:    r = {2'd1, 2'd0, 2'd3};
      3'd3:    r = {2'd0, 2'd2, 2'd3};
      3'd4:    r = {2'd0, 2'd3, 2'd1};
      default: r = {2'd2, 2'd3, 2'd0};
    endcase
    return r;
  endfunction

  // Sampled phases, packed {b, a}.
  function automatic logic [3:0] sec_phase(input logic [2:0] s);
    logic [3:0] r;
    unique case (s)
      3'd0, 3'd1: r = {2'd1, 2'd0};
      3'd2, 3'd3: r = {2'd2, 2'd1};
      default:    r = {2'd2, 2'd0};
    endcase
    return r;
  endfunction

  // Positions of x and y among t1..t3, packed {y, x}.
  function automatic logic [3:0] sec_xy(input logic [2:0] s);
    logic [3:0] r;
    unique case (s)
      3'd0:    r = {2'd1, 2'd0};
      3'd1:    r = {2'd0, 2'd1};
      3'd2:    r = {2'd2, 2'd1};
      3'd3:    r = {2'd1, 2'd2};
      3'd4:    r = {2'd0, 2'd2};
      default: r = {2'd2, 2'd0};
    endcase
    return r;
  endfunction

endpackage

@@ src/svm_compare_and_adc_trigger.sv @@
// Space vector PWM compare and ADC trigger calculator, top level.
// Instantiates svmc_isqrt, svmc_timing and svmc_adc; depends on svmc_pkg.
//
// Each input beat carries an alpha/beta command and an electrical angle and
// yields one output beat with the three phase compares, the ADC trigger
// compare and its direction, the sampled channels and the sector. The block
// is a 25 stage pipeline that takes one beat per clock cycle while it is not
// stalled; sixteen of its stages are the square root that forms the drive
// magnitude. All stages advance together whenever the output register is
// empty or being taken. Configuration writes take effect at once and are
// accepted in every cycle.
module svm_compare_and_adc_trigger (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // alpha_volt [15:0], beta_volt [31:16], rotor_angle [47:32]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // phase1_compare [15:0], phase2_compare [31:16], phase3_compare [47:32],
  // adc_compare [63:48], adc_rising [64], sampled_phase_a [66:65],
  // sampled_phase_b [68:67], sector_index [71:69]
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import svmc_pkg::*;

  logic        ce;
  logic [15:0] half;
  logic [9:0]  dead;
  logic [9:0]  noise;

  logic        v1, v2;
  logic [31:0] aa, bb, sum2;
  logic [18:0] six;
  logic [18:0] six1;
  logic [32:0] angp;
  logic [16:0] xr, xc;
  logic [2:0]  sec2;
  svmc_side_t  side2;

  logic        sq_valid;
  logic [15:0] sq_root;
  svmc_side_t  sq_side;
  logic        tm_valid;
  svmc_tim_t   tm;
  svmc_res_t   res;

  assign ce        = !m_tvalid || m_tready;
  assign s_tready  = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half  <= HALF_RESET;
      dead  <= '0;
      noise <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF:  half  <= cfg_data;
        REG_DEAD:  dead  <= cfg_data[9:0];
        REG_NOISE: noise <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign six = 19'(s_tdata[47:32]) * 19'd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      aa   <= 32'($signed(s_tdata[15:0])) * 32'($signed(s_tdata[15:0]));
      bb   <= 32'($signed(s_tdata[31:16])) * 32'($signed(s_tdata[31:16]));
      six1 <= six;
      sum2 <= aa + bb;
      angp <= 33'(six1[15:0]) * 33'(PI3);
      sec2 <= six1[18:16];
    end
  end

  assign xr = angp[32:16];
  assign xc = (xr < ONE_DEG) ? ONE_DEG : ((xr > DEG_HI) ? DEG_HI : xr);

  always_comb begin
    side2.sector = sec2;
    side2.xb     = xc;
    side2.xa     = PI3 - xc;
  end

  svmc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v2),
    .in_sum    (sum2),
    .in_side   (side2),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  svmc_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .half      (half),
    .out_valid (tm_valid),
    .out_tim   (tm)
  );

  svmc_adc u_adc (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (tm_valid),
    .in_tim    (tm),
    .dead      (dead),
    .noise     (noise),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = res;

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.sector != 3'd6 && res.sector != 3'd7))
    else $error("sector out of range");

  a_phases_differ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.phase_a != res.phase_b))
    else $error("sampled phases coincide");

  a_falling_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.rising) |-> (res.adc <= 16'(11'(dead) + 11'(noise))))
    else $error("falling trigger beyond settle time");

  a_zero_half: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && half == 16'd0) |-> (res.p1 == 16'd0 && res.p2 == 16'd0 && res.p3 == 16'd0))
    else $error("nonzero compare with zero half period");

endmodule

@@ src/svmc_isqrt.sv @@
// Sixteen stage pipelined integer square root of a 32 bit value, one root bit per stage.
// Carries the angle sideband alongside; depends on svmc_pkg.
module svmc_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  logic [31:0]            in_sum,
  input  svmc_pkg::svmc_side_t   in_side,
  output logic                   out_valid,
  output logic [15:0]            out_root,
  output svmc_pkg::svmc_side_t   out_side
);
  import svmc_pkg::*;

  logic [19:0]  rem_q  [16];
  logic [15:0]  root_q [16];
  logic [31:0]  num_q  [16];
  svmc_side_t   side_q [16];
  logic         vld_q  [16];

  for (genvar i = 0; i < 16; i++) begin : g_stage
    logic [19:0] rem_i;
    logic [15:0] root_i;
    logic [31:0] num_i;
    svmc_side_t  side_i;
    logic        v_i;
    logic [19:0] cand;
    logic [19:0] trial;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign num_i  = in_sum;
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_rest
      assign rem_i  = rem_q[i-1];
      assign root_i = root_q[i-1];
      assign num_i  = num_q[i-1];
      assign side_i = side_q[i-1];
      assign v_i    = vld_q[i-1];
    end

    assign cand  = {rem_i[17:0], num_i[31:30]};
    assign trial = {2'b00, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (ce) begin
        vld_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (cand >= trial) begin
          rem_q[i]  <= cand - trial;
          root_q[i] <= {root_i[14:0], 1'b1};
        end else begin
          rem_q[i]  <= cand;
          root_q[i] <= {root_i[14:0], 1'b0};
        end
        num_q[i]  <= {num_i[29:0], 2'b00};
        side_q[i] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[15];
  assign out_root  = root_q[15];
  assign out_side  = side_q[15];

endmodule

@@ src/svmc_timing.sv @@
// Five stage pipeline from drive and in-sector angle to the active and null times.
// Computes the parabolic sines and ta, tb and tn_half; depends on svmc_pkg.
module svmc_timing (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  logic [15:0]            in_root,
  input  svmc_pkg::svmc_side_t   in_side,
  input  logic [15:0]            half,
  output logic                   out_valid,
  output svmc_pkg::svmc_tim_t    out_tim
);
  import svmc_pkg::*;

  logic [14:0] drv;
  logic        va, vb, vc, vd;
  logic [2:0]  sec_a, sec_b, sec_c, sec_d;
  logic [15:0] half_a, half_b, half_c, half_d;
  logic [30:0] hd_a, hd_b, hd_c;
  logic [33:0] p1a_a, p1b_a, sqa_a, sqb_a;
  logic [33:0] p1a_b, p1b_b;
  logic [48:0] p2a_b, p2b_b;
  logic [49:0] diffa, diffb;
  logic [15:0] sina_c, sinb_c;
  logic [46:0] proda, prodb;
  logic [31:0] ta_d, tb_d;
  logic [34:0] tn;

  assign drv = (in_root > 16'(DRIVE_MAX)) ? DRIVE_MAX : in_root[14:0];

  assign diffa = {p1a_b, 16'b0} - 50'(p2a_b);
  assign diffb = {p1b_b, 16'b0} - 50'(p2b_b);
  assign proda = 47'(hd_c) * 47'(sina_c);
  assign prodb = 47'(hd_c) * 47'(sinb_c);
  assign tn    = 35'({half_d, 16'b0}) - 35'(ta_d) - 35'(tb_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sec_a  <= in_side.sector;
      half_a <= half;
      hd_a   <= 31'(half) * 31'(drv);
      p1a_a  <= 34'(in_side.xa) * 34'(SIN_C1);
      p1b_a  <= 34'(in_side.xb) * 34'(SIN_C1);
      sqa_a  <= 34'(in_side.xa) * 34'(in_side.xa);
      sqb_a  <= 34'(in_side.xb) * 34'(in_side.xb);

      sec_b  <= sec_a;
      half_b <= half_a;
      hd_b   <= hd_a;
      p1a_b  <= p1a_a;
      p1b_b  <= p1b_a;
      p2a_b  <= 49'(sqa_a) * 49'(SIN_C2);
      p2b_b  <= 49'(sqb_a) * 49'(SIN_C2);

      sec_c  <= sec_b;
      half_c <= half_b;
      hd_c   <= hd_b;
      sina_c <= diffa[47:32];
      sinb_c <= diffb[47:32];

      sec_d  <= sec_c;
      half_d <= half_c;
      ta_d   <= proda[46:15];
      tb_d   <= prodb[46:15];

      out_tim.sector <= sec_d;
      out_tim.ta     <= ta_d;
      out_tim.tb     <= tb_d;
      out_tim.tnh    <= tn[34] ? 31'd0 : tn[31:1];
    end
  end

endmodule

@@ src/svmc_adc.sv @@
// Two stage back end: saturated compares, sector selection and the ADC trigger rule.
// Holds the output register of the block; depends on svmc_pkg.
module svmc_adc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  svmc_pkg::svmc_tim_t    in_tim,
  input  logic [9:0]             dead,
  input  logic [9:0]             noise,
  output logic                   out_valid,
  output svmc_pkg::svmc_res_t    out_res
);
  import svmc_pkg::*;

  logic [33:0] sum [4];
  logic [15:0] val [4];
  logic [15:0] tsel [4];
  logic [5:0]  src;
  logic [3:0]  xy;
  logic        vf;
  logic [2:0]  sec_f;
  logic [15:0] t1_f, t2_f, t3_f, rx_f, ry_f;
  logic [10:0] tstable;
  logic [17:0] rx3;

  always_comb begin
    sum[0] = 34'(in_tim.tnh);
    sum[1] = 34'(in_tim.tnh) + 34'(in_tim.ta);
    sum[2] = 34'(in_tim.tnh) + 34'(in_tim.tb);
    sum[3] = 34'(in_tim.tnh) + 34'(in_tim.ta) + 34'(in_tim.tb);
    for (int k = 0; k < 4; k++) begin
      val[k] = (|sum[k][33:32]) ? 16'hFFFF : sum[k][31:16];
    end
    src     = sec_src(in_tim.sector);
    xy      = sec_xy(in_tim.sector);
    tsel[0] = val[src[1:0]];
    tsel[1] = val[src[3:2]];
    tsel[2] = val[src[5:4]];
    tsel[3] = '0;
  end

  assign tstable = 11'(dead) + 11'(noise);
  assign rx3     = 18'(rx_f) + {1'b0, rx_f, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vf        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vf        <= in_valid;
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sec_f <= in_tim.sector;
      t1_f  <= tsel[0];
      t2_f  <= tsel[1];
      t3_f  <= tsel[2];
      rx_f  <= tsel[xy[1:0]];
      ry_f  <= tsel[xy[3:2]];

      out_res.sector                     <= sec_f;
      {out_res.phase_b, out_res.phase_a} <= sec_phase(sec_f);
      out_res.p1                         <= t1_f;
      out_res.p2                         <= t2_f;
      out_res.p3                         <= t3_f;
      priority if (rx_f >= 16'(tstable)) begin
        out_res.adc    <= rx_f - 16'(tstable);
        out_res.rising <= 1'b1;
      end else if (18'(ry_f) >= rx3) begin
        out_res.adc    <= 16'(tstable) - rx_f;
        out_res.rising <= 1'b0;
      end else begin
        out_res.adc    <= (ry_f >= 16'(tstable)) ? ry_f - 16'(tstable) : 16'd0;
        out_res.rising <= 1'b1;
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for svm_compare_and_adc_trigger: directed and random beats,
// with its own predictor of the compares and the ADC trigger. Depends on svmc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import svmc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  svmc_res_t   expected_q[$];
  int          errors = 0;
  bit          steady = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          stall_cnt = 0;
  logic [15:0] half_shadow = 16'd4000;
  logic [9:0]  dead_shadow = '0;
  logic [9:0]  noise_shadow = '0;

  logic [1:0] src_tab [6][3] = '{'{0, 1, 3}, '{2, 0, 3}, '{3, 0, 1},
                                 '{3, 2, 0}, '{1, 3, 0}, '{0, 3, 2}};
  logic [1:0] phase_tab [6][2] = '{'{0, 1}, '{0, 1}, '{1, 2}, '{1, 2}, '{0, 2}, '{0, 2}};
  logic [1:0] xy_tab [6][2] = '{'{0, 1}, '{1, 0}, '{1, 2}, '{2, 1}, '{2, 0}, '{0, 2}};

  svm_compare_and_adc_trigger dut (.*);

  always #10 clk = ~clk;

  function automatic longint sat16(longint v);
    if (v < 0) return 0;
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint parabola(longint x);
    longint pos, neg;
    pos = 83443 * x * 65536;
    neg = 26561 * x * x;
    return (pos > neg) ? ((pos - neg) >>> 32) : 0;
  endfunction

  function automatic svmc_res_t predict_compares(logic [47:0] d);
    svmc_res_t r;
    longint a, b, n, root, bitv, drive, six, sec, rem, x, half, ta, tb, tn, tnh;
    longint val[4], t[3], rx, ry, tstable, dt, adc;
    logic rising;
    a = longint'($signed(d[15:0]));
    b = longint'($signed(d[31:16]));
    n = a * a + b * b;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    drive = (root > 28378) ? 28378 : root;
    six = longint'(d[47:32]) * 6;
    sec = six >> 16;
    rem = six - (sec << 16);
    x = (rem * 68629) >> 16;
    if (x < 1144) x = 1144;
    else if (x > 67485) x = 67485;
    if (sec > 5) sec = 5;
    half = longint'(half_shadow);
    ta = (half * drive * parabola(68629 - x)) >>> 15;
    tb = (half * drive * parabola(x)) >>> 15;
    tn = (half << 16) - ta - tb;
    if (tn < 0) tn = 0;
    tnh = tn >>> 1;
    val[0] = sat16(tnh >>> 16);
    val[1] = sat16((tnh + ta) >>> 16);
    val[2] = sat16((tnh + tb) >>> 16);
    val[3] = sat16((tnh + ta + tb) >>> 16);
    for (int i = 0; i < 3; i++) t[i] = val[src_tab[sec][i]];
    rx = t[xy_tab[sec][0]];
    ry = t[xy_tab[sec][1]];
    dt = longint'(dead_shadow);
    tstable = dt + longint'(noise_shadow);
    rising = 1'b1;
    if (rx >= tstable) begin
      adc = rx - tstable;
    end else if (ry - rx >= 2 * rx) begin
      adc = rx - tstable;
      if (adc < 0) begin
        adc = -adc;
        rising = 1'b0;
      end
    end else begin
      adc = ry - tstable;
      if (adc < 0) adc = 0;
    end
    r.p1 = t[0][15:0];
    r.p2 = t[1][15:0];
    r.p3 = t[2][15:0];
    r.adc = 16'(sat16(adc));
    r.rising = rising;
    r.phase_a = phase_tab[sec][0];
    r.phase_b = phase_tab[sec][1];
    r.sector = sec[2:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Output beats are checked at the falling edge before the edge that takes them.
  always @(negedge clk) begin
    svmc_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = svmc_res_t'(m_tdata);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.p1 !== want.p1) report_mismatch("phase1_compare", got.p1, want.p1);
        if (got.p2 !== want.p2) report_mismatch("phase2_compare", got.p2, want.p2);
        if (got.p3 !== want.p3) report_mismatch("phase3_compare", got.p3, want.p3);
        if (got.adc !== want.adc) report_mismatch("adc_compare", got.adc, want.adc);
        if (got.rising !== want.rising) report_mismatch("adc_rising", got.rising, want.rising);
        if (got.phase_a !== want.phase_a)
          report_mismatch("sampled_phase_a", got.phase_a, want.phase_a);
        if (got.phase_b !== want.phase_b)
          report_mismatch("sampled_phase_b", got.phase_b, want.phase_b);
        if (got.sector !== want.sector)
          report_mismatch("sector_index", got.sector, want.sector);
      end
    end
  end

  always @(posedge clk) begin
    int r;
    if (stall_cnt > 0) begin
      m_tready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      m_tready <= 1'b0;
      stall_cnt <= 300;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(99);
      m_tready <= (r < 70);
      if (r >= 95) stall_cnt <= $urandom_range(60, 20);
      else if (r >= 70) stall_cnt <= $urandom_range(2, 0);
    end
  end

  task automatic send_beat(logic [15:0] alpha, logic [15:0] beta, logic [15:0] angle);
    int gap, r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(99);
      if (r >= 95) gap = $urandom_range(40, 10);
      else if (r >= 65) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {angle, beta, alpha};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    expected_q.push_back(predict_compares({angle, beta, alpha}));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HALF:  half_shadow = value;
      REG_DEAD:  dead_shadow = value[9:0];
      REG_NOISE: noise_shadow = value[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_beat();
    logic [15:0] a, b;
    if ($urandom_range(99) < 30) begin
      a = 16'($signed($urandom_range(4000)) - 2000);
      b = 16'($signed($urandom_range(4000)) - 2000);
    end else begin
      a = 16'($urandom);
      b = 16'($urandom);
    end
    send_beat(a, b, 16'($urandom));
  endtask

  task automatic test_directed_extremes();
    logic [15:0] angles[10] = '{0, 65535, 10922, 10923, 21845, 32768, 43690, 54613, 180, 10800};
    for (int i = 0; i < 10; i++) send_beat(16'h7fff, 16'h7fff, angles[i]);
    send_beat(16'h8000, 16'h8000, 16'd5000);
    send_beat(16'h0000, 16'h0000, 16'd30000);
    send_beat(16'h7fff, 16'h0000, 16'd40000);
    send_beat(16'h0000, 16'h8000, 16'd60000);
    send_beat(16'd300, 16'hff00, 16'd12345);
    drain();
  endtask

  task automatic test_adc_cases();
    write_reg(REG_DEAD, 16'd1023);
    write_reg(REG_NOISE, 16'd1023);
    send_beat(16'd100, 16'd50, 16'd3000);
    send_beat(16'h7fff, 16'h7fff, 16'd200);
    send_beat(16'd0, 16'd0, 16'd25000);
    send_beat(16'd8000, 16'd8000, 16'd20000);
    drain();
    write_reg(REG_HALF, 16'd0);
    send_beat(16'h7fff, 16'h8000, 16'd50000);
    send_beat(16'd1000, 16'd1000, 16'd1000);
    drain();
    write_reg(REG_HALF, 16'd65535);
    write_reg(REG_DEAD, 16'd0);
    write_reg(REG_NOISE, 16'd0);
    send_beat(16'h7fff, 16'h7fff, 16'd7000);
    send_beat(16'h8000, 16'h7fff, 16'd33000);
    drain();
  endtask

  task automatic test_random_settings();
    logic [15:0] halves[5] = '{1, 65535, 4000, 0, 0};
    for (int p = 0; p < 5; p++) begin
      halves[3] = 16'($urandom_range(65535, 1));
      halves[4] = 16'($urandom_range(200, 1));
      write_reg(REG_HALF, halves[p]);
      write_reg(REG_DEAD, (p == 1) ? 16'd1023 : 16'($urandom_range(1023)));
      write_reg(REG_NOISE, (p == 2) ? 16'd1023 : 16'($urandom_range(300)));
      steady = (p == 2);
      repeat (80) random_beat();
      steady = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_HALF, 16'd20000);
    steady = 1'b1;
    hold_req++;
    repeat (60) random_beat();
    steady = 1'b0;
    repeat (20) random_beat();
    drain();
    repeat (20) random_beat();
    drain();
    repeat (20) random_beat();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_adc_cases();
    test_random_settings();
    test_backpressure();
    if (errors == 0) $display("[svm_compare_and_adc_trigger] OK");
    else $display("[svm_compare_and_adc_trigger] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[svm_compare_and_adc_trigger] ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
src/svmc_pkg.sv
src/svmc_isqrt.sv
src/svmc_timing.sv
src/svmc_adc.sv
src/svm_compare_and_adc_trigger.sv
dv/tb_top.sv
